/* src/bitmap_1bpp_blitter_core_assert.svh */
// Assertion macros shared by the blitter modules.
`ifndef BITMAP_1BPP_BLITTER_CORE_ASSERT_SVH
`define BITMAP_1BPP_BLITTER_CORE_ASSERT_SVH

// Same-cycle implication, inactive while reset is asserted.
`define BMBLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, inactive while reset is asserted.
`define BMBLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bmblt_pkg.sv */
// Shared types and constants of the 1bpp blitter.
package bmblt_pkg;

    localparam int ADDR_FULL_W = 24;  // unclipped byte address of a clear or draw
    localparam int COL_W       = 10;  // byte column index
    localparam int PITCH_W     = 9;
    localparam int PROD_W      = 22;  // row times pitch
    localparam int ROWS_W      = 14;

    localparam logic [1:0] REQ_DRAW  = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 9'd32;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [10:0] x;
        logic [12:0] y;
        logic [11:0] span_width;
        logic [13:0] rect_height;
        logic [63:0] row_bits;
        logic [12:0] read_address;
    } t_req;

    typedef struct packed {
        logic load_item;
        logic init_step;
        logic setup;
        logic row_start;
        logic col_step;
        logic row_next;
        logic rd_capture;
        logic set_flag;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       empty;
        logic       init_last;
        logic       row_oor;
        logic       addr_oor;
        logic       col_last;
        logic       rows_last;
        logic       out_free;
    } t_dp_sts;

endpackage

/* src/bmblt_req_if.sv */
// Request channel: one blit, clear or read transaction.
interface bmblt_req_if ();
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [10:0] x;
    logic [12:0] y;
    logic [11:0] span_width;
    logic [13:0] rect_height;
    logic [63:0] row_bits;
    logic [12:0] read_address;

    modport source (
        output valid, req_type, x, y, span_width, rect_height, row_bits, read_address,
        input  ready
    );
    modport sink (
        input  valid, req_type, x, y, span_width, rect_height, row_bits, read_address,
        output ready
    );
endinterface

/* src/bmblt_res_if.sv */
// Result channel: one result transaction per request.
interface bmblt_res_if ();
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       out_of_range;

    modport source (output valid, read_data, out_of_range, input ready);
    modport sink (input valid, read_data, out_of_range, output ready);
endinterface

/* src/bmblt_ram.sv */
// Generic simple dual-port RAM with registered read data.
module bmblt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bmblt_ctrl.sv */
// Sequencer of the blitter: clearing pass, row and byte-column walk, result hand-off.
`include "bitmap_1bpp_blitter_core_assert.svh"

module bmblt_ctrl import bmblt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_ROW  = 3'd3;
    localparam logic [2:0] S_COL  = 3'd4;
    localparam logic [2:0] S_RD   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_sts.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.setup = 1'b1;
                if (i_sts.kind inside {REQ_DRAW, REQ_CLEAR}) begin
                    n_state = i_sts.empty ? S_FIN : S_ROW;
                end else if (i_sts.kind == REQ_READ) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_ROW: begin
                // a row that starts past the buffer ends the whole draw or clear
                if (i_sts.row_oor) begin
                    o_cmd.set_flag = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.row_start = 1'b1;
                    n_state         = S_COL;
                end
            end
            S_COL: begin
                o_cmd.col_step = 1'b1;
                o_cmd.set_flag = i_sts.addr_oor;
                if (i_sts.col_last || i_sts.addr_oor) begin
                    if (i_sts.rows_last) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.row_next = 1'b1;
                        n_state        = S_ROW;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_capture = 1'b1;
                o_cmd.set_flag   = i_sts.addr_oor;
                n_state          = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `BMBLT_ASSERT_NEXT(a_accept_decodes, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_DEC, "accepted transaction not decoded")
    `BMBLT_ASSERT_NOW(a_load_needs_slot, i_clk, i_rst_n, o_cmd.out_load, i_sts.out_free, "result loaded over a pending result")

endmodule

/* src/bmblt_dp.sv */
// Datapath of the blitter: address arithmetic, byte masks, frame store and result register.
`include "bitmap_1bpp_blitter_core_assert.svh"

module bmblt_dp import bmblt_pkg::*; #(
    parameter int FB_BYTES       = 8192,
    parameter int MAX_ROW_PIXELS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [PITCH_W-1:0] i_cfg_wdata,
    input  t_req               i_req,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [7:0]         o_read_data,
    output logic               o_out_of_range
);

    localparam int AW    = $clog2(FB_BYTES);
    localparam int SPR_W = MAX_ROW_PIXELS + 8;
    localparam logic [ADDR_FULL_W-1:0] FB_LIMIT = ADDR_FULL_W'(FB_BYTES);

    logic [PITCH_W-1:0]     r_pitch;
    logic [AW-1:0]          r_init_addr;
    logic [1:0]             r_kind;
    logic                   r_empty;
    logic [2:0]             r_x_lo;
    logic [2:0]             r_p1_lo;
    logic [COL_W-1:0]       r_b0;
    logic [COL_W-1:0]       r_b1;
    logic [PROD_W-1:0]      r_prod;
    logic [ADDR_FULL_W-1:0] r_row_addr;
    logic [ADDR_FULL_W-1:0] r_addr;
    logic [COL_W-1:0]       r_col_idx;
    logic [ROWS_W-1:0]      r_row_cnt;
    logic [SPR_W-1:0]       r_spr_data;
    logic [SPR_W-1:0]       r_spr_mask;
    logic                   r_wr_pend;
    logic [AW-1:0]          r_wr_addr;
    logic [7:0]             r_wr_mask;
    logic [7:0]             r_wr_data;
    logic                   r_wr_oor;
    logic [7:0]             r_res_data;
    logic                   r_res_oor;
    logic                   r_out_valid;
    logic [7:0]             r_out_data;
    logic                   r_out_oor;

    logic                      w_draw;
    logic [11:0]               w_span;
    logic [12:0]               w_p1;
    logic [MAX_ROW_PIXELS-1:0] w_fill;
    logic [SPR_W-1:0]          w_spr_data;
    logic [SPR_W-1:0]          w_spr_mask;
    logic                      w_addr_oor;
    logic [7:0]                w_edge_mask;
    logic [7:0]                w_byte_mask;
    logic [7:0]                w_byte_data;
    logic                      w_ram_we;
    logic [AW-1:0]             w_ram_waddr;
    logic [7:0]                w_ram_wdata;
    logic [7:0]                w_ram_rdata;

    // saturate draw width and align the sprite to its first byte
    assign w_draw = (i_req.req_type == REQ_DRAW);
    assign w_span = (w_draw && (i_req.span_width > 12'(MAX_ROW_PIXELS))) ?
                    12'(MAX_ROW_PIXELS) : i_req.span_width;
    assign w_p1   = 13'(i_req.x) + 13'(w_span) - 13'd1;
    assign w_fill = ~({MAX_ROW_PIXELS{1'b1}} >> w_span);
    assign w_spr_data = {i_req.row_bits[63 -: MAX_ROW_PIXELS], 8'h00} >> i_req.x[2:0];
    assign w_spr_mask = {w_fill, 8'h00} >> i_req.x[2:0];

    assign w_addr_oor  = (r_addr >= FB_LIMIT);
    assign w_edge_mask = ((r_col_idx == r_b0) ? (8'hff >> r_x_lo) : 8'hff) &
                         ((r_col_idx == r_b1) ? (8'hff << (3'd7 - r_p1_lo)) : 8'hff);
    assign w_byte_mask = (r_kind == REQ_DRAW) ? r_spr_mask[SPR_W-1 -: 8] : w_edge_mask;
    assign w_byte_data = (r_kind == REQ_DRAW) ? r_spr_data[SPR_W-1 -: 8] : 8'h00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch     <= PITCH_RESET;
            r_init_addr <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pitch <= i_cfg_wdata;
            end
            if (i_cmd.init_step) begin
                r_init_addr <= r_init_addr + AW'(1);
            end
            r_wr_pend <= i_cmd.col_step;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind     <= i_req.req_type;
            r_empty    <= (w_span == 12'd0) ||
                          ((i_req.req_type == REQ_CLEAR) && (i_req.rect_height == 14'd0));
            r_x_lo     <= i_req.x[2:0];
            r_p1_lo    <= w_p1[2:0];
            r_b0       <= COL_W'(i_req.x[10:3]);
            r_b1       <= w_p1[12:3];
            r_prod     <= PROD_W'(i_req.y) * PROD_W'(r_pitch);
            r_row_cnt  <= (i_req.req_type == REQ_CLEAR) ? i_req.rect_height : ROWS_W'(1);
            r_spr_data <= w_spr_data;
            r_spr_mask <= w_spr_mask;
            r_res_data <= 8'h00;
            r_res_oor  <= 1'b0;
        end else begin
            if (i_cmd.col_step) begin
                r_col_idx  <= r_col_idx + COL_W'(1);
                r_spr_data <= r_spr_data << 8;
                r_spr_mask <= r_spr_mask << 8;
            end else if (i_cmd.row_start) begin
                r_col_idx <= r_b0;
            end
            if (i_cmd.row_next) begin
                r_row_cnt <= r_row_cnt - ROWS_W'(1);
            end
            if (i_cmd.rd_capture) begin
                r_res_data <= w_addr_oor ? 8'h00 : w_ram_rdata;
            end
            if (i_cmd.set_flag) begin
                r_res_oor <= 1'b1;
            end
        end

        // a read transaction addresses the store through the same register
        if (i_cmd.load_item) begin
            r_addr <= ADDR_FULL_W'(i_req.read_address);
        end else if (i_cmd.row_start) begin
            r_addr <= r_row_addr;
        end else if (i_cmd.col_step) begin
            r_addr <= r_addr + ADDR_FULL_W'(1);
        end

        if (i_cmd.setup) begin
            r_row_addr <= ADDR_FULL_W'(r_prod) + ADDR_FULL_W'(r_b0);
        end else if (i_cmd.row_next) begin
            r_row_addr <= r_row_addr + ADDR_FULL_W'(r_pitch);
        end

        // write stage of the read-modify-write pipeline
        if (i_cmd.col_step) begin
            r_wr_addr <= r_addr[AW-1:0];
            r_wr_mask <= w_byte_mask;
            r_wr_data <= w_byte_data;
            r_wr_oor  <= w_addr_oor;
        end

        if (i_cmd.out_load) begin
            r_out_data <= r_res_data;
            r_out_oor  <= r_res_oor;
        end
    end

    assign w_ram_we    = i_cmd.init_step || (r_wr_pend && !r_wr_oor);
    assign w_ram_waddr = i_cmd.init_step ? r_init_addr : r_wr_addr;
    assign w_ram_wdata = i_cmd.init_step ? 8'h00 :
                         ((w_ram_rdata & ~r_wr_mask) | (r_wr_data & r_wr_mask));

    bmblt_ram #(
        .WIDTH (8),
        .DEPTH (FB_BYTES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    assign o_sts.kind      = r_kind;
    assign o_sts.empty     = r_empty;
    assign o_sts.init_last = (r_init_addr == AW'(FB_BYTES - 1));
    assign o_sts.row_oor   = (r_row_addr >= FB_LIMIT);
    assign o_sts.addr_oor  = w_addr_oor;
    assign o_sts.col_last  = (r_col_idx == r_b1);
    assign o_sts.rows_last = (r_row_cnt == ROWS_W'(1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_out_data;
    assign o_out_of_range = r_out_oor;

    `BMBLT_ASSERT_NOW(a_write_in_store, i_clk, i_rst_n, w_ram_we, 32'(w_ram_waddr) < 32'(FB_BYTES), "frame store write beyond its depth")
    `BMBLT_ASSERT_NOW(a_nonread_zero, i_clk, i_rst_n, i_cmd.out_load && (r_kind != REQ_READ), r_res_data == 8'h00, "non-read result carries data")

endmodule

/* src/bitmap_1bpp_blitter_core.sv */
// Top level of the 1bpp blitter: request and result channels, pitch register.
//
// One-bit-per-pixel frame buffer of FB_BYTES bytes (bit 7 of a byte is its leftmost
// pixel) with three transactions: draw one sprite row of up to MAX_ROW_PIXELS pixels,
// clear a rectangle, read one byte. Each transaction returns one result; a finished
// result waits in an output register while the next request is taken. Requests are
// handled one at a time. Draw and clear walk the frame store one byte per cycle
// through a pipelined read-modify-write on a single memory read port, and end early
// when a row starts past the end of the buffer. After reset the store is zeroed by a
// clearing pass, during which no request is taken; pitch writes are accepted at any
// time but must only be issued while the block is idle.
module bitmap_1bpp_blitter_core import bmblt_pkg::*; #(
    parameter int FB_BYTES       = 8192,
    parameter int MAX_ROW_PIXELS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [PITCH_W-1:0] i_cfg_wdata,
    bmblt_req_if.sink          i_req,
    bmblt_res_if.source        o_res
);

    t_req    w_req;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign w_req.req_type     = i_req.req_type;
    assign w_req.x            = i_req.x;
    assign w_req.y            = i_req.y;
    assign w_req.span_width   = i_req.span_width;
    assign w_req.rect_height  = i_req.rect_height;
    assign w_req.row_bits     = i_req.row_bits;
    assign w_req.read_address = i_req.read_address;

    assign i_req.ready = w_in_ready;

    bmblt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    bmblt_dp #(
        .FB_BYTES       (FB_BYTES),
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req          (w_req),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_read_data    (o_res.read_data),
        .o_out_of_range (o_res.out_of_range)
    );

endmodule
